/* rtl/core/p1305_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_pkg
// shared constants and types for the poly1305 authenticator
// ----------------------------------------------------------------------------
package p1305_pkg;
    localparam logic [63:0] R_LOW_CLAMP  = 64'h0ffffffc0fffffff;
    localparam logic [63:0] R_HIGH_CLAMP = 64'h0ffffffc0ffffffc;
    localparam int unsigned LIMBS = 5;

    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef logic [25:0] t_limb;
    typedef logic [57:0] t_dsum;

    // control between sequencer and multiply-accumulate unit
    typedef struct packed {
        logic       clr;
        logic       en;
        logic [2:0] col;
        logic [2:0] term;
    } t_mac_ctl;
endpackage

/* rtl/core/p1305_mac_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_mac_unit
// shared 27x29 limb multiplier with a column accumulator, one product a cycle
// ----------------------------------------------------------------------------
module p1305_mac_unit (
    input  logic               i_clk,
    input  p1305_pkg::t_mac_ctl i_ctl,
    input  logic [130:0]       i_h,
    input  logic [129:0]       i_r,
    output logic [57:0]        o_sum
);
    import p1305_pkg::*;

    logic [26:0] w_a;
    logic [28:0] w_b;
    logic [2:0]  w_ri;
    logic        w_wrap;
    logic [25:0] w_rl;
    logic [55:0] r_prod;
    logic        r_pv;
    logic [57:0] r_sum;

    always_comb begin
        // top limb keeps every bit from 104 upward
        w_a    = (i_ctl.term == 3'd4) ? i_h[130:104] : {1'b0, i_h[26*i_ctl.term +: 26]};
        w_wrap = (i_ctl.term > i_ctl.col);
        // r index is col - term modulo five
        w_ri   = w_wrap ? 3'(i_ctl.col + 3'd5 - i_ctl.term) : 3'(i_ctl.col - i_ctl.term);
        w_rl   = i_r[26*w_ri +: 26];
        w_b    = w_wrap ? ({3'b0, w_rl} + {1'b0, w_rl, 2'b0}) : {3'b0, w_rl};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 56'(w_a) * 56'(w_b);
        r_pv   <= i_ctl.en;
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (r_pv) begin
            r_sum <= r_sum + 58'(r_prod);
        end
    end

    assign o_sum = r_sum;
endmodule

/* rtl/core/poly1305_mac_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly1305_mac_top
// poly1305 one-time authenticator, one 16-byte block per beat
// ----------------------------------------------------------------------------
// a block with bytes stalls the input after its beat: 5 columns of 5 limb products
// through one shared multiplier, each followed by a drain state, then 15 one-limb
// carry steps (3 passes of 5) and 1 final reduce; no new block is taken meanwhile
// on a last block the tag beat is offered from ST_OUT after the final reduce, later
// only while an earlier tag beat is still held; a zero-byte block absorbs nothing and stalls the input only if last
// synchronous active-low reset clears key registers, accumulator and control
module poly1305_mac_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_tag_low,
    output logic [63:0] o_tag_high,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import p1305_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_COL  = 3'd2;
    localparam logic [2:0] ST_CRY  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [63:0]  r_rl, r_rh, r_sl, r_sh;
    logic [129:0] r_acc;
    logic [130:0] r_h;
    logic [2:0]   r_st;
    logic [2:0]   r_col, r_term;
    logic [1:0]   r_wait;
    logic [1:0]   r_pass;
    logic         r_last;
    logic [57:0]  r_d [LIMBS];
    logic [63:0]  r_tl, r_th;
    t_mac_ctl     w_ctl;
    logic [57:0]  w_sum;
    logic [127:0] w_r;
    logic [127:0] w_blk;
    logic [129:0] w_msg;
    logic [4:0]   w_n;
    logic [57:0]  w_fold;
    logic [129:0] w_dv;
    logic [130:0] w_g;
    logic         w_acc_in;
    logic [127:0] w_tag;

    assign w_r   = {r_rh & R_HIGH_CLAMP, r_rl & R_LOW_CLAMP};
    assign w_blk = {i_block_high, i_block_low};

    always_comb begin
        w_n   = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        w_msg = '0;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < w_n) begin
                w_msg[8*b +: 8] = w_blk[8*b +: 8];
            end
        end
        w_msg[8*w_n] = 1'b1;
    end

    // column sum is complete on the second drain cycle, cleared there too
    assign w_ctl.clr  = (r_st == ST_IDLE) || ((r_st == ST_COL) && (r_wait == 2'd1));
    assign w_ctl.en   = (r_st == ST_MUL);
    assign w_ctl.col  = r_col;
    assign w_ctl.term = r_term;

    p1305_mac_unit u_mac (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_h   (r_h),
        .i_r   ({2'b0, w_r}),
        .o_sum (w_sum)
    );

    // top overflow folded back times five
    assign w_fold = {26'b0, r_d[4][57:26]} + {24'b0, r_d[4][57:26], 2'b0};
    assign w_dv   = {r_d[4][25:0], r_d[3][25:0], r_d[2][25:0], r_d[1][25:0], r_d[0][25:0]};
    assign w_g    = {1'b0, w_dv} + 131'd5;

    assign w_acc_in = (w_n != 5'd0);
    assign w_tag    = r_acc[127:0] + {r_sh, r_sl};

    assign o_stall     = (r_st != ST_IDLE);
    assign o_cfg_ready = (r_st == ST_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_acc <= '0;
            r_rl <= '0; r_rh <= '0; r_sl <= '0; r_sh <= '0;
            o_valid <= 1'b0;
        end else begin
            if ((r_st == ST_OUT) && (!o_valid || !i_stall)) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_R_LOW:  r_rl <= i_cfg_data;
                    REG_R_HIGH: r_rh <= i_cfg_data;
                    REG_S_LOW:  r_sl <= i_cfg_data;
                    default:    r_sh <= i_cfg_data;
                endcase
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_last <= i_last;
                        r_h    <= {1'b0, r_acc} + {1'b0, w_msg};
                        r_col  <= '0;
                        r_term <= '0;
                        r_st   <= w_acc_in ? ST_MUL : (i_last ? ST_OUT : ST_IDLE);
                    end
                end
                ST_MUL: begin
                    if (r_term == 3'd4) begin
                        r_term <= '0;
                        r_wait <= '0;
                        r_st   <= ST_COL;
                    end else begin
                        r_term <= r_term + 3'd1;
                    end
                end
                ST_COL: begin
                    // wait for the last product to land in the column sum
                    if (r_wait == 2'd1) begin
                        r_d[r_col] <= w_sum;
                        if (r_col == 3'd4) begin
                            r_pass <= '0;
                            r_col  <= '0;
                            r_st   <= ST_CRY;
                        end else begin
                            r_col <= r_col + 3'd1;
                            r_st  <= ST_MUL;
                        end
                    end else begin
                        r_wait <= r_wait + 2'd1;
                    end
                end
                ST_CRY: begin
                    // carry ripples one limb per cycle
                    if (r_col == 3'd4) begin
                        r_d[4] <= {32'b0, r_d[4][25:0]};
                        r_d[0] <= r_d[0] + w_fold;
                        r_col  <= '0;
                        if (r_pass == 2'd2) r_st <= ST_FIN;
                        r_pass <= r_pass + 2'd1;
                    end else begin
                        r_d[r_col]            <= {32'b0, r_d[r_col][25:0]};
                        r_d[3'(r_col + 3'd1)] <= r_d[3'(r_col + 3'd1)] +
                                                 {26'b0, r_d[r_col][57:26]};
                        r_col                 <= r_col + 3'd1;
                    end
                end
                ST_FIN: begin
                    r_acc <= w_g[130] ? w_g[129:0] : w_dv;
                    r_st  <= r_last ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (!o_valid || !i_stall) begin
                        r_tl    <= w_tag[63:0];
                        r_th    <= w_tag[127:64];
                        r_acc   <= '0;
                        r_st    <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_tag_low  = r_tl;
    assign o_tag_high = r_th;
endmodule

/* rtl/core/p1305_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_checker
// port-level checks on the authenticator
// ----------------------------------------------------------------------------
module p1305_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_tag_low,
    input logic        o_cfg_ready,
    input logic [4:0]  i_byte_count,
    input logic        i_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tag_low)) else $error("tag beat dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_byte_count != 5'd0 |=> o_stall) else $error("block not held busy");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_stall) else $error("config during work");
    a_nolast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last && !o_valid |=> !o_valid) else $error("tag invented");
endmodule

bind poly1305_mac_top p1305_checker u_chk (.*);

/* test/poly1305_mac_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly1305_mac_top_test
// self-checking bench for the poly1305 authenticator: a table of directed
// blocks, then random messages under several keys, each tag checked against
// a behavioural model of the 130-bit accumulate/multiply/reduce
// ----------------------------------------------------------------------------
module poly1305_mac_top_test;
    import p1305_pkg::*;

    localparam logic [129:0] PRIME = (130'd1 << 130) - 130'd5;
    localparam int N_RANDOM = 1750;

    typedef struct {
        logic [63:0]  blk_lo;
        logic [63:0]  blk_hi;
        logic [4:0]   count;
        logic         last;
        logic         known;
        logic [127:0] tag;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_block_low = '0;
    logic [63:0] i_block_high = '0;
    logic [4:0]  i_byte_count = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_tag_low;
    logic [63:0] o_tag_high;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // model key and accumulator
    logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [129:0] acc;
    logic [127:0] tag_queue[$];
    int           n_fail = 0;
    bit           rx_quiet = 1'b0;

    poly1305_mac_top u_top (.*);

    always #1 i_clk = ~i_clk;

    // absorb one block into the model accumulator, give its tag and return whether last
    function automatic bit absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] cnt, input logic lst,
                                        output logic [127:0] tag);
        logic [130:0] msg;
        logic [129:0] r_val;
        logic [259:0] prod;
        int           n;
        n = (cnt > 16) ? 16 : int'(cnt);
        if (n != 0) begin
            msg = {3'b0, hi, lo};
            if (n < 16) msg &= (131'd1 << (8 * n)) - 1;
            msg |= 131'd1 << (8 * n);
            r_val = {2'b0, key_r_hi & R_HIGH_CLAMP, key_r_lo & R_LOW_CLAMP};
            prod = (260'(acc) + 260'(msg)) * 260'(r_val);
            acc = 130'(prod % 260'(PRIME));
        end
        tag = acc[127:0] + {key_s_hi, key_s_lo};
        if (lst) acc = '0;
        return lst;
    endfunction

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_R_LOW:  key_r_lo = val;
            REG_R_HIGH: key_r_hi = val;
            REG_S_LOW:  key_s_lo = val;
            default:    key_s_hi = val;
        endcase
    endtask

    task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
        i_valid <= 1'b0;
        while (tag_queue.size() != 0) @(posedge i_clk);
        // a non-last block may still be in the multiplier
        repeat (40) @(posedge i_clk);
        write_key(REG_R_LOW, rl);
        write_key(REG_R_HIGH, rh);
        write_key(REG_S_LOW, sl);
        write_key(REG_S_HIGH, sh);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic lst, input bit gaps);
        logic [127:0] t;
        if (gaps) begin
            while ($urandom_range(99) < 36) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_block_low  <= lo;
        i_block_high <= hi;
        i_byte_count <= cnt;
        i_last       <= lst;
        do @(posedge i_clk); while (o_stall);
        if (absorb_block(lo, hi, cnt, lst, t)) tag_queue.push_back(t);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receive side
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tag_queue.size() == 0) begin
                $error("tag beat with nothing expected: %h_%h", o_tag_high, o_tag_low);
                n_fail++;
            end else begin
                want = tag_queue.pop_front();
                if (o_tag_low !== want[63:0]) begin
                    $error("tag_low expected %h actual %h", want[63:0], o_tag_low);
                    n_fail++;
                end
                if (o_tag_high !== want[127:64]) begin
                    $error("tag_high expected %h actual %h", want[127:64], o_tag_high);
                    n_fail++;
                end
            end
        end
        i_stall <= rx_quiet ? 1'b0 : ($urandom_range(99) < 36);
    end

    initial begin
        t_row         rows[$];
        logic [127:0] t;
        int           msg_len;
        int           k;
        int           seg;
        key_r_lo = '0; key_r_hi = '0; key_s_lo = '0; key_s_hi = '0;
        acc = '0;
        seg = -1;
        // after reset: zero key, so every tag is zero
        rows.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd16, 1'b1,
                         1'b1, 128'h0});
        rows.push_back('{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'h0});
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            send_block(rows[i].blk_lo, rows[i].blk_hi, rows[i].count, rows[i].last, 1'b0);
            if (rows[i].known && tag_queue[$] !== rows[i].tag) begin
                $error("table tag expected %h model %h", rows[i].tag, tag_queue[$]);
                n_fail++;
            end
        end
        // all-ones key: clamps and the reduction at their extremes
        load_key('1, '1, '1, '1);
        rows.delete();
        rows.push_back('{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff});
        rows.push_back('{'1, '1, 5'd16, 1'b0, 1'b0, '0});
        rows.push_back('{'1, '1, 5'd16, 1'b0, 1'b0, '0});
        rows.push_back('{'1, '1, 5'd15, 1'b0, 1'b0, '0});  // short block mid-message
        rows.push_back('{'1, '1, 5'd8, 1'b0, 1'b0, '0});
        rows.push_back('{'1, '1, 5'd7, 1'b0, 1'b0, '0});
        rows.push_back('{'1, '1, 5'd1, 1'b0, 1'b0, '0});
        rows.push_back('{'1, '1, 5'd31, 1'b1, 1'b0, '0});  // count above sixteen
        rows.push_back('{'1, '1, 5'd17, 1'b1, 1'b0, '0});
        rows.push_back('{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, '0});  // absorbs nothing
        rows.push_back('{64'h0, 64'h0, 5'd16, 1'b1, 1'b0, '0});
        rows.push_back('{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd9, 1'b1,
                         1'b0, '0});
        foreach (rows[i]) begin
            if (rows[i].known) begin
                // tag of an empty message is just s
                send_block(rows[i].blk_lo, rows[i].blk_hi, rows[i].count, rows[i].last, 1'b0);
                if (tag_queue[$] !== rows[i].tag) begin
                    $error("table tag expected %h model %h", rows[i].tag, tag_queue[$]);
                    n_fail++;
                end
            end else begin
                send_block(rows[i].blk_lo, rows[i].blk_hi, rows[i].count, rows[i].last, 1'b1);
            end
        end
        // random messages over several keys, one quiet stretch
        k = 0;
        while (k < N_RANDOM) begin
            if (k / 300 != seg) begin
                seg = k / 300;
                case (seg % 3)
                    0: load_key(rand64(), rand64(), rand64(), rand64());
                    1: load_key('0, '1, '0, rand64());
                    default: load_key('1, rand64(), '1, '0);
                endcase
                rx_quiet = (seg == 2);
            end
            msg_len = $urandom_range(6, 1);
            for (int b = 0; b < msg_len; b++) begin
                logic [4:0] cnt;
                logic       lst;
                lst = (b == msg_len - 1);
                if (lst || $urandom_range(9) == 0) cnt = 5'($urandom_range(31));
                else cnt = 5'd16;
                if ($urandom_range(19) == 0) lst = ~lst;  // broken framing
                send_block(rand64(), rand64(), cnt, lst, !rx_quiet);
                k++;
            end
            if (msg_len > 0) send_block(rand64(), rand64(), 5'($urandom_range(16)), 1'b1,
                                        !rx_quiet);
            k++;
        end
        i_valid <= 1'b0;
        rx_quiet = 1'b0;
        while (tag_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/p1305_pkg.sv
rtl/core/p1305_mac_unit.sv
rtl/core/poly1305_mac_top.sv
rtl/core/p1305_checker.sv
test/poly1305_mac_top_test.sv
